// File: design/ffac_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// Holds request and status codes, the hole record and the ALU request type.
// No dependencies.
`default_nettype none

package ffac_pkg;

    // Reset value of the pool size register.
    localparam logic [31:0] POOL_RESET_BYTES = 32'd67108864;
    localparam int HOLE_SLOTS_DEF  = 64;
    localparam int GRANT_SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_COMPACT = 2'd2,
        REQ_RESET   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NOT_HELD = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // One free hole or one granted block: start and length.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_rec;

    // Operands for the shared adder and subtractor.
    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        sub;
    } t_alu_req;

endpackage

`default_nettype wire

// File: design/ffac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/ffac_alu.sv
// Shared 33-bit adder and subtractor used by the arithmetic steps of the sequencer.
// Depends on ffac_pkg for the request type.
`default_nettype none

module ffac_alu (
    input  wire ffac_pkg::t_alu_req i_req,
    output logic [33:0]             o_res
);

    import ffac_pkg::*;

    // Bit 33 of a difference is set when a is below b.
    always_comb begin
        o_res = {1'b0, i_req.a} + ({1'b0, i_req.b} ^ {34{i_req.sub}})
              + {33'd0, i_req.sub};
    end

endmodule

`default_nettype wire

// File: design/first_fit_allocator_coalescing_core.sv
// First-fit pool allocator with free-list coalescing, one request at a time.
// Each request runs to completion before the next is taken: busy stays high through the
// one-cycle o_done pulse, and the receiver cannot stall. The steps run one after another,
// as the hole memory has a single port and the adder is shared.
// After reset the block writes the first hole in S_INIT before it goes idle.
`default_nettype none

module first_fit_allocator_coalescing_core #(
    parameter int HOLE_SLOTS  = ffac_pkg::HOLE_SLOTS_DEF,
    parameter int GRANT_SLOTS = ffac_pkg::GRANT_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [16:0] i_align_bytes,
    input  wire logic [31:0] i_free_offset,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_block_offset,
    output logic [31:0]      o_usage_bytes,
    output logic [31:0]      o_peak_bytes,
    output logic [31:0]      o_alloc_total,
    output logic [31:0]      o_free_total,
    output logic [31:0]      o_largest_free_bytes,
    output logic [31:0]      o_sum_free_bytes
);

    import ffac_pkg::*;

    localparam int HIW = $clog2(HOLE_SLOTS);
    localparam int HCW = $clog2(HOLE_SLOTS + 1);
    localparam int GIW = (GRANT_SLOTS > 1) ? $clog2(GRANT_SLOTS) : 1;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_RST, S_ARND, S_AFRD, S_AFCK, S_AGRD, S_AGCK,
        S_SHRD, S_SHWR, S_SPL1, S_SPL2, S_SPL3, S_AGW, S_APK,
        S_FGRD, S_FGCK, S_FAPP, S_FUSE,
        S_SORT0, S_SRA, S_SRD, S_SCK,
        S_MRG0, S_MRA, S_MRD, S_MCK, S_MAD,
        S_ST0, S_STRD, S_STCK, S_DONE
    } t_state;

    t_state           r_state;
    logic [31:0]      r_pool;
    logic [HCW-1:0]   r_cnt;
    logic [HCW-1:0]   r_j;
    logic [HCW-1:0]   r_wr;
    logic [HCW-1:0]   r_hit;
    logic [GRANT_SLOTS-1:0] r_valid;
    logic [GIW-1:0]   r_gj;
    logic [GIW-1:0]   r_gslot;
    logic             r_gfree_ok;
    logic             r_swap;
    t_req             r_req;
    logic [31:0]      r_size;
    logic [16:0]      r_align;
    logic [31:0]      r_addr;
    logic [32:0]      r_round;
    logic [32:0]      r_t;
    logic [31:0]      r_base;
    logic [31:0]      r_blen;
    logic [31:0]      r_flen;
    t_rec             r_a;
    logic [31:0]      r_usage;
    logic [31:0]      r_peak;
    logic [31:0]      r_allocs;
    logic [31:0]      r_frees;
    logic [31:0]      r_largest;
    logic [31:0]      r_sum;
    t_status          r_status;
    logic [31:0]      r_off;

    t_alu_req         alu_req;
    logic [33:0]      alu_res;

    logic             hole_we;
    logic [HIW-1:0]   hole_waddr;
    t_rec             hole_wdata;
    logic [HIW-1:0]   hole_raddr;
    t_rec             hole_rdata;

    logic             grant_we;
    t_rec             grant_rdata;

    logic [HIW-1:0]   j_idx;
    logic [HIW-1:0]   j_m1;
    logic [HIW-1:0]   cnt_idx;
    logic [HIW-1:0]   cnt_m1;
    logic [HIW-1:0]   wr_idx;
    logic             g_last;
    logic             g_valid;

    assign j_idx   = r_j[HIW-1:0];
    assign j_m1    = HIW'(r_j - 1'b1);
    assign cnt_idx = r_cnt[HIW-1:0];
    assign cnt_m1  = HIW'(r_cnt - 1'b1);
    assign wr_idx  = r_wr[HIW-1:0];
    assign g_last  = (r_gj == GIW'(GRANT_SLOTS - 1));
    assign g_valid = r_valid[r_gj];

    // Hole list memory.
    ffac_ram #(.WIDTH(64), .DEPTH(HOLE_SLOTS)) u_hole_ram (
        .i_clk   (i_clk),
        .i_we    (hole_we),
        .i_waddr (hole_waddr),
        .i_wdata (hole_wdata),
        .i_raddr (hole_raddr),
        .o_rdata (hole_rdata)
    );

    // Grant table memory; entries are only trusted while their valid bit is set.
    ffac_ram #(.WIDTH(64), .DEPTH(GRANT_SLOTS)) u_grant_ram (
        .i_clk   (i_clk),
        .i_we    (grant_we),
        .i_waddr (r_gslot),
        .i_wdata ({r_base, r_round[31:0]}),
        .i_raddr (r_gj),
        .o_rdata (grant_rdata)
    );

    // Shared arithmetic unit.
    ffac_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_ARND: begin
                alu_req.a = {1'b0, r_size};
                alu_req.b = {16'd0, r_align - 17'd1};
            end
            S_AFCK: begin
                alu_req.a   = {1'b0, hole_rdata.len};
                alu_req.b   = r_round;
                alu_req.sub = 1'b1;
            end
            S_SPL1: begin
                alu_req.a = r_round;
                alu_req.b = {16'd0, r_align};
            end
            S_SPL2: begin
                alu_req.a = {1'b0, r_base};
                alu_req.b = r_round;
            end
            S_SPL3: begin
                alu_req.a   = {1'b0, r_blen};
                alu_req.b   = r_round;
                alu_req.sub = 1'b1;
            end
            S_AGW: begin
                alu_req.a = {1'b0, r_usage};
                alu_req.b = {1'b0, r_round[31:0]};
            end
            S_APK: begin
                alu_req.a   = {1'b0, r_peak};
                alu_req.b   = {1'b0, r_usage};
                alu_req.sub = 1'b1;
            end
            S_FUSE: begin
                alu_req.a   = {1'b0, r_usage};
                alu_req.b   = {1'b0, r_flen};
                alu_req.sub = 1'b1;
            end
            S_MCK: begin
                alu_req.a = {1'b0, r_a.start};
                alu_req.b = {1'b0, r_a.len};
            end
            S_MAD: begin
                alu_req.a = {1'b0, r_a.len};
                alu_req.b = {1'b0, hole_rdata.len};
            end
            S_STCK: begin
                alu_req.a = {1'b0, r_sum};
                alu_req.b = {1'b0, hole_rdata.len};
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // Hole memory port control.
    always_comb begin
        hole_we    = 1'b0;
        hole_waddr = '0;
        hole_wdata = r_a;
        hole_raddr = j_idx;
        unique case (r_state)
            S_INIT, S_RST: begin
                hole_we    = 1'b1;
                hole_wdata = '{start: 32'd0, len: r_pool};
            end
            S_SHWR: begin
                hole_we    = 1'b1;
                hole_waddr = j_m1;
                hole_wdata = hole_rdata;
            end
            S_SPL3: begin
                hole_we    = 1'b1;
                hole_waddr = cnt_idx;
                hole_wdata = '{start: r_t[31:0], len: alu_res[31:0]};
            end
            S_FAPP: begin
                hole_we    = 1'b1;
                hole_waddr = cnt_idx;
                hole_wdata = '{start: r_addr, len: r_flen};
            end
            S_SORT0, S_MRG0: begin
                hole_raddr = '0;
            end
            S_SRD: begin
                hole_we    = (r_j == r_cnt);
                hole_waddr = cnt_m1;
            end
            S_SCK: begin
                hole_we    = 1'b1;
                hole_waddr = j_m1;
                hole_wdata = (r_a.start > hole_rdata.start) ? hole_rdata : r_a;
            end
            S_MRD: begin
                hole_we    = (r_j == r_cnt);
                hole_waddr = wr_idx;
            end
            S_MCK: begin
                hole_we    = (alu_res[32:0] != {1'b0, hole_rdata.start});
                hole_waddr = wr_idx;
            end
            default: begin
                hole_we = 1'b0;
            end
        endcase
    end

    assign grant_we = (r_state == S_AGW);

    // Sequencer and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_pool     <= POOL_RESET_BYTES;
            r_cnt      <= HCW'(1);
            r_valid    <= '0;
            r_usage    <= '0;
            r_peak     <= '0;
            r_allocs   <= '0;
            r_frees    <= '0;
            r_j        <= '0;
            r_wr       <= '0;
            r_gj       <= '0;
            r_gfree_ok <= 1'b0;
            r_swap     <= 1'b0;
            r_status   <= ST_OK;
            r_off      <= '0;
            r_largest  <= '0;
            r_sum      <= '0;
            r_req      <= REQ_ALLOC;
        end else begin
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_req    <= t_req'(i_req_type);
                        r_size   <= i_request_bytes;
                        r_align  <= (i_align_bytes == 17'd0) ? 17'd1 : i_align_bytes;
                        r_addr   <= i_free_offset;
                        r_status <= ST_OK;
                        r_off    <= '0;
                        r_gj     <= '0;
                        r_gfree_ok <= 1'b0;
                        unique case (t_req'(i_req_type))
                            REQ_ALLOC:   r_state <= S_ARND;
                            REQ_FREE:    r_state <= S_FGRD;
                            REQ_COMPACT: r_state <= (r_cnt == '0) ? S_ST0 : S_SORT0;
                            REQ_RESET:   r_state <= S_RST;
                            default:     r_state <= S_ST0;
                        endcase
                    end
                end
                S_RST: begin
                    r_cnt    <= (r_pool != 32'd0) ? HCW'(1) : '0;
                    r_valid  <= '0;
                    r_usage  <= '0;
                    r_peak   <= '0;
                    r_allocs <= '0;
                    r_frees  <= '0;
                    r_state  <= S_ST0;
                end
                // Round the size up to the alignment; the mask keeps bit 32, so a carry
                // into bit 32 means the rounded size does not fit in 32 bits.
                S_ARND: begin
                    r_round <= alu_res[32:0] & ~{16'd0, r_align - 17'd1};
                    if (alu_res[32]) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_ST0;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_AFRD;
                    end
                end
                // First-fit scan over the hole list.
                S_AFRD: begin
                    if (r_j == r_cnt) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_ST0;
                    end else begin
                        r_state <= S_AFCK;
                    end
                end
                S_AFCK: begin
                    if (!alu_res[33]) begin
                        r_hit   <= r_j;
                        r_base  <= hole_rdata.start;
                        r_blen  <= hole_rdata.len;
                        r_state <= S_AGRD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_AFRD;
                    end
                end
                // Grant slot search: same start first, else first empty slot.
                S_AGRD: begin
                    r_state <= S_AGCK;
                end
                S_AGCK: begin
                    if (g_valid && grant_rdata.start == r_base) begin
                        r_gslot <= r_gj;
                        r_j     <= r_hit + 1'b1;
                        r_state <= S_SHRD;
                    end else begin
                        if (!g_valid && !r_gfree_ok) begin
                            r_gfree_ok <= 1'b1;
                            r_gslot    <= r_gj;
                        end
                        if (g_last) begin
                            if (r_gfree_ok || !g_valid) begin
                                r_j     <= r_hit + 1'b1;
                                r_state <= S_SHRD;
                            end else begin
                                r_status <= ST_FULL;
                                r_state  <= S_ST0;
                            end
                        end else begin
                            r_gj    <= r_gj + 1'b1;
                            r_state <= S_AGRD;
                        end
                    end
                end
                // Remove the chosen hole by moving later entries down.
                S_SHRD: begin
                    if (r_j == r_cnt) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_SPL1;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SHRD;
                end
                // Split only when the hole exceeds rounded size plus alignment.
                S_SPL1: begin
                    r_t     <= alu_res[32:0];
                    r_state <= S_SPL2;
                end
                S_SPL2: begin
                    if ({1'b0, r_blen} > r_t) begin
                        r_t     <= alu_res[32:0];
                        r_state <= S_SPL3;
                    end else begin
                        r_state <= S_AGW;
                    end
                end
                S_SPL3: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_AGW;
                end
                S_AGW: begin
                    r_valid[r_gslot] <= 1'b1;
                    r_usage  <= alu_res[31:0];
                    r_off    <= r_base;
                    r_state  <= S_APK;
                end
                S_APK: begin
                    if (alu_res[33]) begin
                        r_peak <= r_usage;
                    end
                    r_allocs <= r_allocs + 32'd1;
                    r_state  <= S_ST0;
                end
                // Free: look up the grant by its start.
                S_FGRD: begin
                    r_state <= S_FGCK;
                end
                S_FGCK: begin
                    if (g_valid && grant_rdata.start == r_addr) begin
                        r_gslot <= r_gj;
                        r_flen  <= grant_rdata.len;
                        if (r_cnt >= HCW'(HOLE_SLOTS)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_ST0;
                        end else begin
                            r_state <= S_FAPP;
                        end
                    end else if (g_last) begin
                        r_status <= ST_NOT_HELD;
                        r_state  <= S_ST0;
                    end else begin
                        r_gj    <= r_gj + 1'b1;
                        r_state <= S_FGRD;
                    end
                end
                S_FAPP: begin
                    r_valid[r_gslot] <= 1'b0;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_SORT0;
                end
                S_FUSE: begin
                    r_usage <= alu_res[31:0];
                    r_frees <= r_frees + 32'd1;
                    r_state <= S_ST0;
                end
                // Stable bubble pass over the hole list, repeated until clean.
                S_SORT0: begin
                    r_j     <= HCW'(1);
                    r_swap  <= 1'b0;
                    r_state <= S_SRA;
                end
                S_SRA: begin
                    r_a     <= hole_rdata;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    if (r_j == r_cnt) begin
                        r_state <= r_swap ? S_SORT0 : S_MRG0;
                    end else begin
                        r_state <= S_SCK;
                    end
                end
                S_SCK: begin
                    if (r_a.start > hole_rdata.start) begin
                        r_swap <= 1'b1;
                    end else begin
                        r_a <= hole_rdata;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SRD;
                end
                // Merge pass: fold touching neighbours into the running hole.
                S_MRG0: begin
                    r_j     <= HCW'(1);
                    r_wr    <= '0;
                    r_state <= S_MRA;
                end
                S_MRA: begin
                    r_a     <= hole_rdata;
                    r_state <= S_MRD;
                end
                S_MRD: begin
                    if (r_j == r_cnt) begin
                        r_cnt   <= r_wr + 1'b1;
                        r_state <= (r_req == REQ_FREE) ? S_FUSE : S_ST0;
                    end else begin
                        r_state <= S_MCK;
                    end
                end
                S_MCK: begin
                    if (alu_res[32:0] == {1'b0, hole_rdata.start}) begin
                        r_state <= S_MAD;
                    end else begin
                        r_wr    <= r_wr + 1'b1;
                        r_a     <= hole_rdata;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_MAD: begin
                    r_a.len <= alu_res[32] ? 32'hFFFFFFFF : alu_res[31:0];
                    r_j     <= r_j + 1'b1;
                    r_state <= S_MRD;
                end
                // Largest hole and saturated sum over the list.
                S_ST0: begin
                    r_j       <= '0;
                    r_sum     <= '0;
                    r_largest <= '0;
                    r_state   <= S_STRD;
                end
                S_STRD: begin
                    r_state <= (r_j == r_cnt) ? S_DONE : S_STCK;
                end
                S_STCK: begin
                    r_sum <= alu_res[32] ? 32'hFFFFFFFF : alu_res[31:0];
                    if (hole_rdata.len > r_largest) begin
                        r_largest <= hole_rdata.len;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= S_STRD;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result ports.
    assign busy                 = (r_state != S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_status             = r_status;
    assign o_block_offset       = r_off;
    assign o_usage_bytes        = r_usage;
    assign o_peak_bytes         = r_peak;
    assign o_alloc_total        = r_allocs;
    assign o_free_total         = r_frees;
    assign o_largest_free_bytes = r_largest;
    assign o_sum_free_bytes     = r_sum;

endmodule

`default_nettype wire

// File: dv/first_fit_allocator_coalescing_core_tb.sv
// Testbench for the first-fit pool allocator with free-list coalescing.
// It predicts every request with its own pool tracker and checks each result in order.
// Depends on ffac_pkg and first_fit_allocator_coalescing_core.
`timescale 1ns / 1ps

import ffac_pkg::*;

// Expected contents of one result transfer.
typedef struct {
    t_status     status;
    logic [31:0] offset;
    logic [31:0] usage;
    logic [31:0] peak;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [31:0] largest;
    logic [31:0] sum;
} t_pool_result;

// Tracks the hole list, the grant table and the counters, and checks results.
class pool_tracker;
    localparam int HOLES  = HOLE_SLOTS_DEF;
    localparam int GRANTS = GRANT_SLOTS_DEF;

    logic [31:0]  pool_cap_bytes;
    logic [31:0]  hole_base[HOLES];
    logic [31:0]  hole_len[HOLES];
    int           holes;
    logic [31:0]  grant_base[GRANTS];
    logic [31:0]  grant_len[GRANTS];
    bit           granted[GRANTS];
    logic [31:0]  usage, peak, allocs, frees;
    t_pool_result pending_results[$];
    int           errors;

    function new();
        pool_cap_bytes = POOL_RESET_BYTES;
        errors = 0;
        restart_pool();
    endfunction

    function void restart_pool();
        for (int i = 0; i < GRANTS; i++) begin
            granted[i] = 0;
            grant_base[i] = '0;
            grant_len[i] = '0;
        end
        for (int i = 0; i < HOLES; i++) begin
            hole_base[i] = '0;
            hole_len[i] = '0;
        end
        holes = 0;
        if (pool_cap_bytes != 0) begin
            hole_len[0] = pool_cap_bytes;
            holes = 1;
        end
        usage = '0;
        peak = '0;
        allocs = '0;
        frees = '0;
    endfunction

    // Stable insertion sort by start, then merge touching neighbors.
    function void sort_and_merge();
        logic [31:0] s, l;
        logic [32:0] total;
        int          j, i;
        if (holes == 0) return;
        for (i = 1; i < holes; i++) begin
            s = hole_base[i];
            l = hole_len[i];
            j = i;
            while (j > 0 && hole_base[j-1] > s) begin
                hole_base[j] = hole_base[j-1];
                hole_len[j] = hole_len[j-1];
                j--;
            end
            hole_base[j] = s;
            hole_len[j] = l;
        end
        i = 0;
        while (i + 1 < holes) begin
            if ({1'b0, hole_base[i]} + {1'b0, hole_len[i]} == {1'b0, hole_base[i+1]}) begin
                total = {1'b0, hole_len[i]} + {1'b0, hole_len[i+1]};
                hole_len[i] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                for (j = i + 1; j + 1 < holes; j++) begin
                    hole_base[j] = hole_base[j+1];
                    hole_len[j] = hole_len[j+1];
                end
                holes--;
            end else begin
                i++;
            end
        end
    endfunction

    function t_status allocate(logic [31:0] size, logic [16:0] align, output logic [31:0] base);
        logic [63:0] al, rounded;
        logic [31:0] blen;
        int          i, slot;
        base = '0;
        al = (align == 0) ? 64'd1 : {47'd0, align};
        rounded = ({32'd0, size} + al - 64'd1) & ~(al - 64'd1);
        if (rounded > 64'hFFFF_FFFF) return ST_NO_FIT;
        for (i = 0; i < holes; i++)
            if ({32'd0, hole_len[i]} >= rounded) break;
        if (i >= holes) return ST_NO_FIT;
        base = hole_base[i];
        blen = hole_len[i];
        slot = -1;
        for (int g = 0; g < GRANTS; g++)
            if (slot < 0 && granted[g] && grant_base[g] == base) slot = g;
        for (int g = 0; g < GRANTS; g++)
            if (slot < 0 && !granted[g]) slot = g;
        if (slot < 0) begin
            base = '0;
            return ST_FULL;
        end
        for (int j = i; j + 1 < holes; j++) begin
            hole_base[j] = hole_base[j+1];
            hole_len[j] = hole_len[j+1];
        end
        holes--;
        // The remainder goes to the tail of the list only past rounded plus alignment.
        if ({32'd0, blen} > rounded + al) begin
            hole_base[holes] = base + rounded[31:0];
            hole_len[holes] = blen - rounded[31:0];
            holes++;
        end
        granted[slot] = 1;
        grant_base[slot] = base;
        grant_len[slot] = rounded[31:0];
        usage += rounded[31:0];
        if (usage > peak) peak = usage;
        allocs++;
        return ST_OK;
    endfunction

    function t_status release_block(logic [31:0] addr);
        int slot;
        slot = -1;
        for (int g = 0; g < GRANTS; g++)
            if (slot < 0 && granted[g] && grant_base[g] == addr) slot = g;
        if (slot < 0) return ST_NOT_HELD;
        if (holes >= HOLES) return ST_FULL;
        granted[slot] = 0;
        hole_base[holes] = addr;
        hole_len[holes] = grant_len[slot];
        holes++;
        sort_and_merge();
        usage -= grant_len[slot];
        frees++;
        return ST_OK;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(t_req req, logic [31:0] size, logic [16:0] align,
                               logic [31:0] addr);
        t_pool_result r;
        logic [63:0]  total;
        r.offset = '0;
        r.status = ST_OK;
        case (req)
            REQ_ALLOC:   r.status = allocate(size, align, r.offset);
            REQ_FREE:    r.status = release_block(addr);
            REQ_COMPACT: sort_and_merge();
            default:     restart_pool();
        endcase
        if (r.status != ST_OK) r.offset = '0;
        total = '0;
        r.largest = '0;
        for (int i = 0; i < holes; i++) begin
            total += {32'd0, hole_len[i]};
            if (hole_len[i] > r.largest) r.largest = hole_len[i];
        end
        r.sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        r.usage = usage;
        r.peak = peak;
        r.allocs = allocs;
        r.frees = frees;
        pending_results = {pending_results, r};
    endfunction

    // Picks a random live grant; returns 0 when none is live.
    function bit pick_granted(output logic [31:0] addr);
        int live[$];
        addr = '0;
        for (int g = 0; g < GRANTS; g++)
            if (granted[g]) live = {live, g};
        if (live.size() == 0) return 0;
        addr = grant_base[live[$urandom_range(0, live.size() - 1)]];
        return 1;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(t_pool_result got);
        t_pool_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", got.status, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.offset != want.offset) report_mismatch("block_offset", got.offset, want.offset);
        if (got.usage != want.usage) report_mismatch("usage_bytes", got.usage, want.usage);
        if (got.peak != want.peak) report_mismatch("peak_bytes", got.peak, want.peak);
        if (got.allocs != want.allocs) report_mismatch("alloc_total", got.allocs, want.allocs);
        if (got.frees != want.frees) report_mismatch("free_total", got.frees, want.frees);
        if (got.largest != want.largest)
            report_mismatch("largest_free_bytes", got.largest, want.largest);
        if (got.sum != want.sum) report_mismatch("sum_free_bytes", got.sum, want.sum);
    endtask
endclass

module first_fit_allocator_coalescing_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_request_bytes = '0;
    logic [16:0] i_align_bytes = '0;
    logic [31:0] i_free_offset = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [31:0] o_block_offset, o_usage_bytes, o_peak_bytes, o_alloc_total;
    logic [31:0] o_free_total, o_largest_free_bytes, o_sum_free_bytes;

    pool_tracker tracker;
    int          burst_left = 0;

    first_fit_allocator_coalescing_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_request_bytes(i_request_bytes),
        .i_align_bytes(i_align_bytes), .i_free_offset(i_free_offset),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_status(o_status), .o_block_offset(o_block_offset),
        .o_usage_bytes(o_usage_bytes), .o_peak_bytes(o_peak_bytes),
        .o_alloc_total(o_alloc_total), .o_free_total(o_free_total),
        .o_largest_free_bytes(o_largest_free_bytes), .o_sum_free_bytes(o_sum_free_bytes)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Every result transfer is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_pool_result got;
        if (i_rst_n && o_done) begin
            got.status = t_status'(o_status);
            got.offset = o_block_offset;
            got.usage = o_usage_bytes;
            got.peak = o_peak_bytes;
            got.allocs = o_alloc_total;
            got.frees = o_free_total;
            got.largest = o_largest_free_bytes;
            got.sum = o_sum_free_bytes;
            tracker.check_result(got);
        end
    end

    // Issues one request from a falling edge and returns at the falling edge after transfer.
    task issue(t_req req, logic [31:0] size, logic [16:0] align, logic [31:0] addr);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_req_type = req;
        i_request_bytes = size;
        i_align_bytes = align;
        i_free_offset = addr;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        tracker.note_request(req, size, align, addr);
        @(negedge i_clk);
    endtask

    task wait_idle();
        start = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Writes the pool size while idle; it takes effect on the next pool reset.
    task write_pool_size(logic [31:0] bytes);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_wdata = bytes;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.pool_cap_bytes = bytes;
    endtask

    function logic [16:0] random_align();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 17'd0;
        if (pick == 1) return 17'($urandom());
        return 17'd1 << $urandom_range(0, 16);
    endfunction

    task random_requests(int count);
        int          pick;
        logic [31:0] size, addr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            size = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 600))
                 : ($urandom_range(0, 1) != 0) ? $urandom() % (tracker.pool_cap_bytes / 4 + 1)
                 : $urandom();
            if (pick < 48) begin
                issue(REQ_ALLOC, size, random_align(), $urandom());
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0 || !tracker.pick_granted(addr)) addr = $urandom();
                issue(REQ_FREE, $urandom(), random_align(), addr);
            end else if (pick < 96) begin
                issue(REQ_COMPACT, $urandom(), random_align(), $urandom());
            end else begin
                issue(REQ_RESET, $urandom(), random_align(), $urandom());
            end
        end
    endtask

    initial begin
        logic [31:0] addr;
        logic [31:0] pool_sizes[6];
        tracker = new();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, every request type and the corner cases.
        issue(REQ_ALLOC, 32'd0, 17'd0, 32'd0);
        issue(REQ_ALLOC, 32'd100, 17'd3, 32'd0);
        issue(REQ_ALLOC, 32'd1, 17'h10000, 32'd0);
        issue(REQ_ALLOC, 32'hFFFF_FFFF, 17'd1, 32'd0);
        issue(REQ_ALLOC, 32'hFFFF_FFFF, 17'h10000, 32'd0);
        issue(REQ_ALLOC, 32'd4096, 17'h1FFFF, 32'd0);
        issue(REQ_ALLOC, 32'd64, 17'd64, 32'hFFFF_FFFF);
        issue(REQ_FREE, 32'hFFFF_FFFF, 17'd1, 32'hFFFF_FFFF);
        issue(REQ_FREE, 32'd0, 17'd1, 32'd0);
        issue(REQ_FREE, 32'd0, 17'd1, 32'd0);
        if (tracker.pick_granted(addr)) issue(REQ_FREE, 32'd0, 17'd1, addr);
        issue(REQ_COMPACT, 32'd0, 17'd1, 32'd0);
        issue(REQ_RESET, 32'd0, 17'd1, 32'd0);
        issue(REQ_ALLOC, 32'd67108864, 17'd1, 32'd0);
        issue(REQ_COMPACT, 32'd0, 17'd1, 32'd0);
        issue(REQ_FREE, 32'd0, 17'd1, 32'd0);

        // Fill the grant table with small blocks until it reports full.
        write_pool_size(32'd1 << 20);
        issue(REQ_RESET, 32'd0, 17'd1, 32'd0);
        for (int k = 0; k < 66; k++) issue(REQ_ALLOC, 32'd16, 17'd1, 32'd0);
        for (int k = 0; k < 64; k += 2) issue(REQ_FREE, 32'd0, 17'd1, 32'(k * 16));
        issue(REQ_COMPACT, 32'd0, 17'd1, 32'd0);

        // Empty pool: reset leaves no holes and compact leaves them alone.
        write_pool_size(32'd0);
        issue(REQ_RESET, 32'd0, 17'd1, 32'd0);
        issue(REQ_COMPACT, 32'd0, 17'd1, 32'd0);
        issue(REQ_ALLOC, 32'd0, 17'd1, 32'd0);

        // Random phases over several pool sizes, extremes included.
        pool_sizes = '{32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd65536, POOL_RESET_BYTES, $urandom()};
        foreach (pool_sizes[p]) begin
            write_pool_size(pool_sizes[p]);
            issue(REQ_RESET, 32'd0, 17'd1, 32'd0);
            random_requests(160);
        end

        wait_idle();
        repeat (50) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("first_fit_allocator_coalescing_core_tb: PASS");
        end else begin
            $display("first_fit_allocator_coalescing_core_tb: FAIL");
        end
        $finish;
    end

    // Run limit, well beyond the slowest legal run.
    initial begin
        #(2_000_000_000);
        $display("first_fit_allocator_coalescing_core_tb: FAIL");
        $finish;
    end

endmodule
